FILE: sv/itrd_pkg.sv
// itrd_pkg: shared widths, character codes and the digit-to-character mapping
// for the integer to radix text converter
// no dependencies
package itrd_pkg;

  // fixed field widths
  localparam int VALUE_W = 64;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W  = 8;

  // parameter defaults
  localparam int VALUE_BITS_DEFAULT = 64;
  localparam int MAX_DIGITS_DEFAULT = 64;

  // radix register
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h41;
  localparam logic [CHAR_W-1:0] DEC_DIGITS = 8'd10;

  // digit value to its ascii character, letters upper case from ten upwards
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-DIGIT_W){1'b0}}, d};
    if (dw >= DEC_DIGITS) begin
      digit_char = dw - DEC_DIGITS + CHAR_ALPHA;
    end else begin
      digit_char = dw + CHAR_ZERO;
    end
  endfunction

endpackage

FILE: sv/itrd_divider.sv
// itrd_divider: bit-serial restoring divider, one quotient bit per cycle
// divides a VALUE_BITS magnitude by the radix; uses itrd_pkg
module itrd_divider
  import itrd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_W-1:0]    divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_W-1:0]    remainder
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RADIX_W:0] partial;
  logic [RADIX_W:0] diff;
  logic             fits;

  // shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    partial = {remainder, quotient[VALUE_BITS-1]};
    diff    = partial - {1'b0, divisor};
    fits    = partial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      cnt       <= CNT_W'(VALUE_BITS - 1);
    end else if (busy) begin
      quotient  <= {quotient[VALUE_BITS-2:0], fits};
      remainder <= fits ? diff[RADIX_W-1:0] : partial[RADIX_W-1:0];
      cnt       <= cnt - 1'b1;
    end
  end

endmodule

FILE: sv/itrd_digit_store.sv
// itrd_digit_store: digit memory, one write port and one registered read port
// uses itrd_pkg for the digit width
module itrd_digit_store
  import itrd_pkg::*;
#(
  parameter int DEPTH = MAX_DIGITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DIGIT_W-1:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DIGIT_W-1:0]       rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/integer_to_radix_digits.sv
// integer_to_radix_digits: signed integer to ascii text in radix 2..36, one character per request
// each digit takes one full divider pass, lowest digit first; then comes the sign of a negative
//   value, then the digits are read back from the store; character stalls lengthen a conversion
//   a new value is taken only in idle, once the last character of the previous one has been issued
// reset (rst, synchronous): idle, radix back to ten, no character pending; digit memory not cleared
// uses itrd_pkg, itrd_divider and itrd_digit_store
module integer_to_radix_digits
  import itrd_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
  parameter int MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               radix_we,
  input  logic [RADIX_W-1:0] radix_wdata,
  // value requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  // character requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  character,
  output logic               last
);

  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  // sequencer: divide repeatedly, then sign for a negative value, then read digits back top down
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DIV  = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_READ = 5'b01000,
    ST_LOAD = 5'b10000
  } state_t;

  state_t              state;
  logic [RADIX_W-1:0]  radix;
  logic [CNT_W-1:0]    count;
  logic                neg;
  logic [RADIX_W-1:0]  base;
  logic [ADDR_W-1:0]   idx;

  // input side decode
  logic [VALUE_BITS-1:0] v_in;
  logic [VALUE_BITS-1:0] v_neg;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  neg_in;
  logic [RADIX_W-1:0]    base_in;
  logic                  accept;
  logic                  out_free;

  // divider and store hookup
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quotient;
  logic [RADIX_W-1:0]    div_remainder;
  logic                  quot_zero;
  logic                  store_we;
  logic                  store_re;
  logic [DIGIT_W-1:0]    store_rdata;

  always_comb begin
    // only the low VALUE_BITS bits count, as a two's complement number
    v_in   = value[VALUE_BITS-1:0];
    neg_in = v_in[VALUE_BITS-1];
    v_neg  = (~v_in) + {{(VALUE_BITS-1){1'b0}}, 1'b1};
    if (!neg_in) begin
      mag_in = v_in;
    end else if (v_neg[VALUE_BITS-1]) begin
      // most negative value: magnitude saturates to the largest positive
      mag_in = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      mag_in = v_neg;
    end

    // out of range radix is pulled back to 2..36
    if (radix < RADIX_MIN) begin
      base_in = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      base_in = RADIX_MAX;
    end else begin
      base_in = radix;
    end

    in_stall = (state != ST_IDLE);
    accept   = in_valid && (state == ST_IDLE);
    out_free = !out_valid || !out_stall;

    quot_zero    = (div_quotient == '0);
    // the quotient of one pass is the dividend of the next, until it reaches zero
    div_start    = accept || (state == ST_DIV && div_done && !quot_zero);
    div_dividend = accept ? mag_in : div_quotient;

    // beyond MAX_DIGITS the more significant digits are dropped
    store_we = (state == ST_DIV) && div_done && (count < CNT_W'(MAX_DIGITS));
    store_re = (state == ST_READ);
  end

  itrd_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (accept ? base_in : base),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  itrd_digit_store #(
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (div_remainder),
    .re    (store_re),
    .raddr (idx),
    .rdata (store_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      radix     <= RADIX_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (radix_we) begin
        radix <= radix_wdata;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            count <= '0;
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (store_we) begin
              count <= count + 1'b1;
            end
            if (quot_zero) begin
              state <= neg ? ST_SIGN : ST_READ;
            end
          end
        end
        ST_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= (idx == '0) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          neg  <= neg_in;
          base <= base_in;
        end
      end
      ST_DIV: begin
        if (div_done && quot_zero) begin
          // top digit sits at the last written address
          idx <= store_we ? count[ADDR_W-1:0] : ADDR_W'(count - 1'b1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          character <= CHAR_MINUS;
          last      <= 1'b0;
        end
      end
      ST_READ: begin
      end
      ST_LOAD: begin
        if (out_free) begin
          character <= digit_char(store_rdata);
          last      <= (idx == '0);
          if (idx != '0) begin
            idx <= idx - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  // the sign character is only produced for negative values
  assert property (@(posedge clk) disable iff (rst)
    state == ST_SIGN |-> neg)
    else $error("sign phase entered for a non-negative value");

  // the digit count never passes the memory depth
  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  // handing over the lowest digit ends the value and flags it last
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD && out_free && idx == '0) |=> (state == ST_IDLE && out_valid && last))
    else $error("final digit not flagged or sequencer not back to idle");

  // no value is taken while digits are still being produced
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_READ || state == ST_LOAD) |-> in_stall)
    else $error("value request open during conversion");

endmodule

FILE: test/itrd_text_checker.sv
// itrd_text_checker: watches the value and character requests of the radix text converter,
// predicts the text of every accepted value and compares it character by character
// depends on itrd_pkg for widths and character codes
module itrd_text_checker
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               radix_we,
  input  logic [RADIX_W-1:0] radix_wdata,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [VALUE_W-1:0] value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [CHAR_W-1:0]  character,
  input  logic               last,
  output int                 mismatches,
  output int                 pending,
  output int                 values_taken,
  output int                 chars_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              final_char;
  } text_char_t;

  localparam logic [VALUE_W-1:0] MAG_LIMIT = {1'b0, {(VALUE_W-1){1'b1}}};

  logic [RADIX_W-1:0] radix_shadow;
  text_char_t         expected_text[$];
  text_char_t         head;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch, %s", $time, what);
    mismatches++;
  endtask

  // text of one value, sign first, then digits most significant first
  function automatic void predict_text(input logic [VALUE_W-1:0] v,
                                       input logic [RADIX_W-1:0] r);
    logic               negative;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] digits [64];
    logic [CHAR_W-1:0]  wide;
    text_char_t         entry;
    int                 n;
    negative = v[VALUE_W-1];
    mag = negative ? -v : v;
    // most negative value has no positive twin
    if (mag > MAG_LIMIT) begin
      mag = MAG_LIMIT;
    end
    if (r < RADIX_MIN) begin
      base = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      base = RADIX_MAX;
    end else begin
      base = r;
    end
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % base);
      n++;
      mag = mag / base;
    end while (mag != 0);
    if (negative) begin
      entry.code = CHAR_MINUS;
      entry.final_char = 1'b0;
      expected_text.push_back(entry);
    end
    for (int i = n - 1; i >= 0; i--) begin
      wide = {{(CHAR_W-DIGIT_W){1'b0}}, digits[i]};
      entry.code = (wide >= DEC_DIGITS) ? wide - DEC_DIGITS + CHAR_ALPHA : wide + CHAR_ZERO;
      entry.final_char = (i == 0);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radix_shadow <= RADIX_RESET;
      expected_text.delete();
      pending <= 0;
      mismatches = 0;
      values_taken = 0;
      chars_taken = 0;
    end else begin
      // compare before predicting so a stray character is never matched
      if (out_valid && !out_stall) begin
        chars_taken++;
        if (expected_text.size() == 0) begin
          report_mismatch($sformatf("character %h with nothing expected", character));
        end else begin
          head = expected_text.pop_front();
          if (character !== head.code) begin
            report_mismatch($sformatf("character %h, expected %h", character, head.code));
          end
          if (last !== head.final_char) begin
            report_mismatch($sformatf("last %b on %h, expected %b",
                                      last, character, head.final_char));
          end
        end
      end
      if (in_valid && !in_stall) begin
        predict_text(value, radix_shadow);
        values_taken++;
      end
      if (radix_we) begin
        radix_shadow <= radix_wdata;
      end
      pending <= expected_text.size();
    end
  end

endmodule

FILE: test/tb_integer_to_radix_digits.sv
// tb_integer_to_radix_digits: stimulus and verdict for the integer to radix text converter
// drives directed corners and random values over many radix settings, bursty value requests
// and a patterned character stall; depends on itrd_pkg, the block and itrd_text_checker
module tb_integer_to_radix_digits
  import itrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // worst run is well under 15 ms, so this only trips on a hang
  localparam int LIMIT_NS = 60_000_000;
  // tail after the last character, sized for one full conversion of the longest (63-digit) value
  localparam int TAIL_CYCLES = 4400;

  localparam logic [VALUE_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MIN_NEG = 64'h8000_0000_0000_0000;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

  logic               clk;
  logic               rst;
  logic               radix_we;
  logic [RADIX_W-1:0] radix_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [VALUE_W-1:0] value;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CHAR_W-1:0]  character;
  logic               last;

  int                 mismatches;
  int                 pending;
  int                 values_taken;
  int                 chars_taken;

  // stimulus bookkeeping
  int                 burst_left = 0;
  int                 radix_writes = 0;
  logic [RADIX_W-1:0] radix_now = RADIX_RESET;

  integer_to_radix_digits dut (
    .clk        (clk),
    .rst        (rst),
    .radix_we   (radix_we),
    .radix_wdata(radix_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .character  (character),
    .last       (last)
  );

  itrd_text_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .radix_we    (radix_we),
    .radix_wdata (radix_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .character   (character),
    .last        (last),
    .mismatches  (mismatches),
    .pending     (pending),
    .values_taken(values_taken),
    .chars_taken (chars_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // character stall: modes of random length, from never stalling to mostly stalling
  initial begin
    stall_mode_t mode;
    int          left;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0) begin
        mode = stall_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 400);
      end
      left--;
      case (mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= (left % 5 < 2);
      endcase
    end
  end

  // one value request; valid stays up through the stall, then a burst either
  // carries on or a gap follows, sometimes long enough to land mid-conversion
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 4);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 2500) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      // junk on the payload while nothing is offered
      value    <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every predicted character has come back
  task automatic drain;
    in_valid <= 1'b0;
    // let the checker's count take in the final request first
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // radix writes only happen with the block idle
  task automatic write_radix(input logic [RADIX_W-1:0] r);
    radix_we    <= 1'b1;
    radix_wdata <= r;
    @(posedge clk);
    radix_we    <= 1'b0;
    radix_now   = r;
    radix_writes++;
  endtask

  // random value: full range, short magnitudes, powers of the base either side,
  // and the range ends; sign chosen at random for the short magnitudes and the powers
  function automatic logic [VALUE_W-1:0] pick_value(input logic [RADIX_W-1:0] r);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] b;
    logic [VALUE_W-1:0] limit;
    int                 steps;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end else begin
      b = r;
    end
    limit = MAX_POS / b;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {$urandom, $urandom};
      4, 5: mag = {$urandom, $urandom} >> $urandom_range(1, 63);
      6, 7: begin
        // digit count boundaries
        mag = 1;
        steps = $urandom_range(0, 63);
        repeat (steps) if (mag <= limit) mag = mag * b;
        mag = mag + $urandom_range(0, 2) - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return MAX_POS;
          2:       return MIN_NEG;
          default: return MIN_NEG + 1;
        endcase
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      mag = -mag;
    end
    return mag;
  endfunction

  initial begin
    logic [RADIX_W-1:0] phase_radix [8];
    rst         <= 1'b1;
    radix_we    <= 1'b0;
    radix_wdata <= '0;
    in_valid    <= 1'b0;
    value       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // decimal after reset: zero, small values, both range ends, alternating bits
    send_value(64'd0);
    send_value(64'd1);
    send_value(-64'd1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(-64'd10);
    send_value(MAX_POS);
    send_value(MIN_NEG);
    send_value(MIN_NEG + 1);
    send_value(64'd1234567890);
    send_value(64'hAAAA_AAAA_AAAA_AAAA);
    send_value(64'h5555_5555_5555_5555);
    drain();

    // top radix: the letter 'Z' and the roll into two digits
    write_radix(6'd36);
    send_value(64'd35);
    send_value(64'd36);
    send_value(-64'd35);
    send_value(MAX_POS);
    drain();

    // binary: the longest texts
    write_radix(6'd2);
    send_value(64'd5);
    send_value(MIN_NEG);
    drain();

    // radix below two behaves as binary
    write_radix(6'd0);
    send_value(64'd6);
    send_value(-64'd1);
    drain();
    write_radix(6'd1);
    send_value(64'd3);
    drain();

    // radix above thirty-six behaves as base 36
    write_radix(6'd63);
    send_value(64'd35);
    send_value(64'd1295);
    send_value(-64'd36);
    drain();

    // random phases, each under its own radix, the extremes among them
    phase_radix = '{6'd16, 6'd2, 6'd36, 6'd8, 6'd37, 6'd0, 6'd3, 6'd10};
    phase_radix[5] = $urandom_range(0, 63);
    foreach (phase_radix[p]) begin
      write_radix(phase_radix[p]);
      repeat (15) send_value(pick_value(radix_now));
      drain();
    end

    // anything spurious after the final character shows up in this window
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("converted %0d values into %0d characters over %0d radix settings",
             values_taken, chars_taken, radix_writes + 1);
    $display("radix settings from 0 to 63: directed corners first, then random values per setting");
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d characters still owed", mismatches, pending);
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("timed out with %0d characters still owed", pending);
    $display("FAIL");
    $finish;
  end

endmodule

FILE: integer_to_radix_digits.f
sv/itrd_pkg.sv
sv/itrd_divider.sv
sv/itrd_digit_store.sv
sv/integer_to_radix_digits.sv
test/itrd_text_checker.sv
test/tb_integer_to_radix_digits.sv
